>>> src/brsd_pkg.sv
// ----------------------------------------------------------------------------
// brsd_pkg
// types and constants shared by the 24-bit bmp stream decoder
// ----------------------------------------------------------------------------
package brsd_pkg;

   // fixed widths of the transfer fields
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 12;
   localparam int IMG_DIM_W = 13;
   localparam int KIND_W    = 3;
   localparam int HDR_IDX_W = 6;
   localparam int ACC_W     = 32;

   localparam int MAX_DIM_DEFAULT = 4096;

   // header layout (little-endian, 14 byte file header + 40 byte info header)
   localparam logic [HDR_IDX_W-1:0] SIG_IDX      = HDR_IDX_W'(1);
   localparam logic [HDR_IDX_W-1:0] WIDTH_IDX    = HDR_IDX_W'(21);
   localparam logic [HDR_IDX_W-1:0] HEIGHT_IDX   = HDR_IDX_W'(25);
   localparam logic [HDR_IDX_W-1:0] BPP_IDX      = HDR_IDX_W'(29);
   localparam logic [HDR_IDX_W-1:0] COMP_IDX     = HDR_IDX_W'(33);
   localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(14 + 40 - 1);

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [15:0] BPP_RGB24     = 16'd24;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_IDLE
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL,
      KIND_BAD_SIG,
      KIND_BAD_COMP,
      KIND_BAD_SIZE,
      KIND_BAD_BPP
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    red;
      logic [BYTE_W-1:0]    green;
      logic [BYTE_W-1:0]    blue;
      kind_type             kind;
      logic                 last;
      logic [POS_W-1:0]     column;
      logic [POS_W-1:0]     row;
      logic [IMG_DIM_W-1:0] image_width;
      logic [IMG_DIM_W-1:0] image_height;
   } rsp_type;

endpackage

>>> src/bmp_rgb24_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp_rgb24_stream_decoder_core
// byte-serial decoder for uncompressed 24-bit bmp files
// ----------------------------------------------------------------------------
// Takes a bmp file one byte per transfer (req_start_req marks byte 0 of a new
// file and restarts the parse at any time) and gives one rgb pixel per three
// stored b,g,r bytes, bottom row first, with row padding skipped and the final
// pixel flagged by rsp_last. The 54 byte header is checked for the 0x4D42
// signature, compression 0, width and height in 1..MAX_DIM and 24 bits per
// pixel; the first failing check gives a single error result (rsp_kind) and
// further bytes are dropped until the next start. Pixel data is taken from
// byte 54 on; the header's data offset field is not used. After reset the
// block is at byte 0 of a header, so a stream without a start flag still
// parses. Rate: one byte per clock while req_stall is low; each result is
// registered from the header/pixel counters; a two-entry output stage (result
// register plus skid register) keeps input transfers going while a result
// waits, so req_stall rises only when both entries are full.
// ----------------------------------------------------------------------------
module bmp_rgb24_stream_decoder_core
   import brsd_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // input byte channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_start_req,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_red,
   output logic [BYTE_W-1:0]    rsp_green,
   output logic [BYTE_W-1:0]    rsp_blue,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic                 rsp_last,
   output logic [POS_W-1:0]     rsp_column,
   output logic [POS_W-1:0]     rsp_row,
   output logic [IMG_DIM_W-1:0] rsp_image_width,
   output logic [IMG_DIM_W-1:0] rsp_image_height
);

   // width of a stored dimension (holds MAX_DIM) and of a position counter
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   width_ok_ff, width_ok_in;
   logic                   height_ok_ff, height_ok_in;
   logic                   bpp_ok_ff, bpp_ok_in;
   logic                   comp_bad_ff, comp_bad_in;
   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [CNT_W-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]       row_ff, row_in;
   logic [1:0]             bip_ff, bip_in;
   logic [1:0]             pad_ff, pad_in;
   logic [BYTE_W-1:0]      blue_ff, blue_in;
   logic [BYTE_W-1:0]      green_ff, green_in;

   // output stage
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   logic                   skid_valid_ff, skid_valid_in;
   rsp_type                skid_ff, skid_in;

   // per-byte decode
   logic                   in_fire;
   logic                   out_take;
   phase_type              cur_phase;
   logic [HDR_IDX_W-1:0]   cur_idx;
   logic [ACC_W-1:0]       acc_next;
   logic                   hdr_byte;
   logic                   pix_byte;
   logic                   sig_bad;
   logic                   hdr_done;
   logic                   pix_emit;
   logic                   col_wrap;
   logic                   is_last;
   logic [DIM_W-1:0]       col_plus;
   logic [DIM_W-1:0]       row_plus;
   logic                   res_valid;
   rsp_type                res;

   function automatic logic dim_ok(input logic [ACC_W-1:0] v);
      dim_ok = (v != '0) && !v[ACC_W-1] && (v <= ACC_W'(MAX_DIM));
   endfunction

   assign in_fire  = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;

   // a start flag restarts the parse before the byte is taken
   assign cur_phase = req_start_req ? PH_HEADER : phase_ff;
   assign cur_idx   = req_start_req ? '0 : hdr_idx_ff;
   assign acc_next  = {req_data_byte, acc_ff[ACC_W-1:BYTE_W]};

   assign hdr_byte = in_fire && (cur_phase == PH_HEADER);
   assign pix_byte = in_fire && (cur_phase == PH_PIXELS);
   assign sig_bad  = hdr_byte && (cur_idx == SIG_IDX) &&
                     (acc_next[ACC_W-1:16] != BMP_SIGNATURE);
   assign hdr_done = hdr_byte && (cur_idx == LAST_HDR_IDX);

   assign col_plus = DIM_W'(col_ff) + DIM_W'(1);
   assign row_plus = DIM_W'(row_ff) + DIM_W'(1);
   assign col_wrap = (col_plus == width_ff);
   assign is_last  = col_wrap && (row_plus == height_ff);
   // third byte of a pixel, padding done
   assign pix_emit = pix_byte && (pad_ff == 2'd0) && (bip_ff == 2'd2);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_fire) begin
         case (cur_phase)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               if (sig_bad) begin
                  phase_in = PH_IDLE;
               end else if (hdr_done) begin
                  if (comp_bad_ff || !width_ok_ff || !height_ok_ff || !bpp_ok_ff) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_PIXELS;
                  end
               end
            end
            PH_PIXELS: begin
               phase_in = (pix_emit && is_last) ? PH_IDLE : PH_PIXELS;
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // header capture, pixel counters and the result of this byte
   always_comb begin
      hdr_idx_in   = hdr_idx_ff;
      acc_in       = acc_ff;
      width_ok_in  = width_ok_ff;
      height_ok_in = height_ok_ff;
      bpp_ok_in    = bpp_ok_ff;
      comp_bad_in  = comp_bad_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bip_in       = bip_ff;
      pad_in       = pad_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      res_valid    = 1'b0;
      res          = '0;

      if (hdr_byte) begin
         acc_in     = acc_next;
         hdr_idx_in = cur_idx + HDR_IDX_W'(1);
         if (cur_idx == WIDTH_IDX) begin
            width_ok_in = dim_ok(acc_next);
            width_in    = acc_next[DIM_W-1:0];
         end
         if (cur_idx == HEIGHT_IDX) begin
            height_ok_in = dim_ok(acc_next);
            height_in    = acc_next[DIM_W-1:0];
         end
         if (cur_idx == BPP_IDX) begin
            bpp_ok_in = (acc_next[ACC_W-1:16] == BPP_RGB24);
         end
         if (cur_idx == COMP_IDX) begin
            comp_bad_in = (acc_next != '0);
         end
         // checks in order: signature, compression, size, depth
         if (sig_bad) begin
            res_valid = 1'b1;
            res.kind  = KIND_BAD_SIG;
         end else if (hdr_done) begin
            col_in = '0;
            row_in = '0;
            bip_in = 2'd0;
            pad_in = 2'd0;
            if (comp_bad_ff) begin
               res_valid = 1'b1;
               res.kind  = KIND_BAD_COMP;
            end else if (!width_ok_ff || !height_ok_ff) begin
               res_valid = 1'b1;
               res.kind  = KIND_BAD_SIZE;
            end else if (!bpp_ok_ff) begin
               res_valid = 1'b1;
               res.kind  = KIND_BAD_BPP;
            end
         end
      end else if (pix_byte) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            case (bip_ff)
               2'd0: begin
                  blue_in = req_data_byte;
                  bip_in  = 2'd1;
               end
               2'd1: begin
                  green_in = req_data_byte;
                  bip_in   = 2'd2;
               end
               default: begin
                  bip_in           = 2'd0;
                  res_valid        = 1'b1;
                  res.red          = req_data_byte;
                  res.green        = green_ff;
                  res.blue         = blue_ff;
                  res.kind         = KIND_PIXEL;
                  res.last         = is_last;
                  res.column       = POS_W'(col_ff);
                  res.row          = POS_W'(row_ff);
                  res.image_width  = IMG_DIM_W'(width_ff);
                  res.image_height = IMG_DIM_W'(height_ff);
                  if (!is_last) begin
                     if (col_wrap) begin
                        col_in = '0;
                        row_in = CNT_W'(row_plus);
                        // 3*w bytes padded to a multiple of four: w mod 4 bytes
                        pad_in = 2'(width_ff);
                     end else begin
                        col_in = CNT_W'(col_plus);
                     end
                  end
               end
            endcase
         end
      end
   end

   // result register with a skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_idx_ff    <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         bip_ff        <= 2'd0;
         pad_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         bip_ff        <= bip_in;
         pad_ff        <= pad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload and header capture, always rewritten before use
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      width_ok_ff  <= width_ok_in;
      height_ok_ff <= height_ok_in;
      bpp_ok_ff    <= bpp_ok_in;
      comp_bad_ff  <= comp_bad_in;
      width_ff     <= width_in;
      height_ff    <= height_in;
      blue_ff      <= blue_in;
      green_ff     <= green_in;
      out_ff       <= out_in;
      skid_ff      <= skid_in;
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = out_ff.red;
   assign rsp_green        = out_ff.green;
   assign rsp_blue         = out_ff.blue;
   assign rsp_kind         = out_ff.kind;
   assign rsp_last         = out_ff.last;
   assign rsp_column       = out_ff.column;
   assign rsp_row          = out_ff.row;
   assign rsp_image_width  = out_ff.image_width;
   assign rsp_image_height = out_ff.image_height;

   // skid entry is only ever filled behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty result register");

   // any error result ends the parse
   a_error_idles: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.kind != KIND_PIXEL)) |=> (phase_ff == PH_IDLE))
      else $error("parse continued after an error result");

   // the last pixel ends the parse
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last) |=> (phase_ff == PH_IDLE))
      else $error("parse continued after the last pixel");

   // while pixels flow the column stays inside the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXELS) |-> ((DIM_W'(col_ff) < width_ff) && (bip_ff != 2'd3)))
      else $error("column counter outside the image row");

endmodule
